// ===== rtl/core/mscu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscu_pkg
// Shared types, widths and register codes of the magnetometer sample
// calibrator.
// ----------------------------------------------------------------------------
package mscu_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int SCALE_W    = 24;
	localparam int AXIS_W     = 16;
	localparam int TERM_W     = 29;   // Q.12 value after offset removal
	localparam int PROD_W     = TERM_W + AXIS_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int FIELD_W    = 32;
	localparam int Q12_SHIFT  = 12;
	localparam int Q14_SHIFT  = 14;
	localparam int STEP_W     = 4;
	localparam int NUM_PROD   = 12;   // three scale products, nine matrix products

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE    = 3'd0,
		REG_HARD_IRON = 3'd1,
		REG_COEFF_XX = 3'd2,
		REG_COEFF_XY = 3'd3,
		REG_COEFF_XZ = 3'd4,
		REG_COEFF_YY = 3'd5,
		REG_COEFF_YZ = 3'd6,
		REG_COEFF_ZZ = 3'd7
	} cfg_reg_t;

	localparam logic [SCALE_W-1:0]        SCALE_RST     = 24'd25166;
	localparam logic [CFG_DATA_W-1:0]     HARD_IRON_RST = 48'd29149616215304;
	localparam logic signed [AXIS_W-1:0]  COEFF_XX_RST  = 16'sd16062;
	localparam logic signed [AXIS_W-1:0]  COEFF_XY_RST  = -16'sd173;
	localparam logic signed [AXIS_W-1:0]  COEFF_XZ_RST  = 16'sd124;
	localparam logic signed [AXIS_W-1:0]  COEFF_YY_RST  = 16'sd15575;
	localparam logic signed [AXIS_W-1:0]  COEFF_YZ_RST  = -16'sd582;
	localparam logic signed [AXIS_W-1:0]  COEFF_ZZ_RST  = 16'sd17605;

	typedef logic signed [AXIS_W-1:0]  s16_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [FIELD_W-1:0] field_t;

	typedef struct packed {
		logic [7:0] byte_x_low;
		logic [7:0] byte_x_high;
		logic [7:0] byte_y_low;
		logic [7:0] byte_y_high;
		logic [7:0] byte_z_low;
		logic [7:0] byte_z_high;
		logic       bus_error;
	} sample_t;

	typedef struct packed {
		logic         status;
		logic signed [AXIS_W-1:0]  avg_x;
		logic signed [AXIS_W-1:0]  avg_y;
		logic signed [AXIS_W-1:0]  avg_z;
		logic signed [FIELD_W-1:0] field_x;
		logic signed [FIELD_W-1:0] field_y;
		logic signed [FIELD_W-1:0] field_z;
	} result_t;

	// tag that travels with each product through the multiplier register
	typedef struct packed {
		logic       valid;
		logic       to_q12;   // scale product: form an offset-corrected term
		logic       first;    // first product of a matrix row
		logic       last;     // last product of a matrix row
		logic [1:0] idx;      // axis for scale products, row for matrix products
	} mul_tag_t;

endpackage

// ===== rtl/core/mscu_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscu_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface mscu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mscu_mul_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscu_mul_unit
// Shared signed multiplier with registered product and tag.
// ----------------------------------------------------------------------------
module mscu_mul_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  mscu_pkg::term_t   op_a,
	input  mscu_pkg::s16_t    op_b,
	input  mscu_pkg::mul_tag_t tag,
	output mscu_pkg::prod_t   prod_s1,
	output mscu_pkg::mul_tag_t tag_s1
);
	import mscu_pkg::*;

	prod_t prod;

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
	end

endmodule

// ===== rtl/core/mscu_acc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscu_acc_unit
// Consumes registered products: forms the offset-corrected Q.12 terms and
// accumulates the matrix rows with shift and saturation.
// ----------------------------------------------------------------------------
module mscu_acc_unit (
	input  logic               clk,
	input  mscu_pkg::prod_t    prod_s1,
	input  mscu_pkg::mul_tag_t tag_s1,
	input  mscu_pkg::s16_t     offset [3],
	output mscu_pkg::term_t    term_q [3],
	output mscu_pkg::field_t   field_q [3]
);
	import mscu_pkg::*;

	logic signed [ACC_W-1:0]         acc_q;
	logic signed [ACC_W-1:0]         sum;
	logic signed [ACC_W-Q14_SHIFT-1:0] shifted;
	term_t                           scaled;
	term_t                           term;
	field_t                          sat;

	// scale product stays below 2^39 in magnitude, so bits 40:12 hold it
	assign scaled  = prod_s1[TERM_W+Q12_SHIFT-1:Q12_SHIFT];
	assign term    = scaled - TERM_W'(offset[tag_s1.idx]);
	assign sum     = (tag_s1.first ? '0 : acc_q) + ACC_W'(prod_s1);
	assign shifted = sum[ACC_W-1:Q14_SHIFT];

	always_comb begin
		if (shifted[ACC_W-Q14_SHIFT-1] != shifted[FIELD_W-1]) begin
			sat = shifted[ACC_W-Q14_SHIFT-1] ? {1'b1, {(FIELD_W-1){1'b0}}}
			                                 : {1'b0, {(FIELD_W-1){1'b1}}};
		end else begin
			sat = shifted[FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			if (tag_s1.to_q12) begin
				term_q[tag_s1.idx] <= term;
			end else if (tag_s1.last) begin
				field_q[tag_s1.idx] <= sat;
			end else begin
				acc_q <= sum;
			end
		end
	end

endmodule

// ===== rtl/core/magnetometer_sample_calibrator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_sample_calibrator_unit
// Averages a raw magnetometer sample with the kept previous average, scales
// it, removes hard-iron offsets and applies the soft-iron matrix.
// ----------------------------------------------------------------------------
//  channel   dir  payload    transfer
//  sample    in   sample_t   valid & ready
//  result    out  result_t   valid & ready
//  cfg       in   index/data cfg_we, no back-pressure
//
//  a good sample passes through the accept, 13 sequencer steps through the
//  single shared multiplier (12 products plus one drain step) and the load
//  of the output register; a failed read goes from the accept straight to
//  the output load; reset clears the sequencer and the kept averages and
//  reloads the default settings
//  a stalled result holds the block in its last step until the output frees;
//  the next sample may be taken while a finished result still waits
// ----------------------------------------------------------------------------
module magnetometer_sample_calibrator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	mscu_stream_if.sink                         sample,
	mscu_stream_if.source                       result,
	input  logic                                cfg_we,
	input  logic [mscu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mscu_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mscu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [STEP_W-1:0]      step_q;
	logic                   err_q;
	s16_t                   prev_q [3];
	logic [SCALE_W-1:0]     scale_q;
	logic [CFG_DATA_W-1:0]  hard_iron_q;
	s16_t                   cxx_q, cxy_q, cxz_q, cyy_q, cyz_q, czz_q;
	logic                   out_valid_q;
	result_t                out_q;

	s16_t                   raw [3];
	s16_t                   oriented [3];
	s16_t                   avg_new [3];
	logic signed [AXIS_W:0] pair_sum [3];
	logic signed [AXIS_W:0] pair_adj [3];
	s16_t                   offset [3];
	term_t                  term_q [3];
	field_t                 field_q [3];
	term_t                  op_a;
	s16_t                   op_b;
	mul_tag_t               tag;
	prod_t                  prod_s1;
	mul_tag_t               tag_s1;
	logic                   accept;
	logic                   out_free;

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	assign sample.ready   = (state_q == ST_IDLE);
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	assign raw[0] = {sample.payload.byte_x_high, sample.payload.byte_x_low};
	assign raw[1] = {sample.payload.byte_y_high, sample.payload.byte_y_low};
	assign raw[2] = {sample.payload.byte_z_high, sample.payload.byte_z_low};
	assign oriented[0] = raw[0];
	assign oriented[1] = AXIS_W'(-raw[1]);
	assign oriented[2] = AXIS_W'(-raw[2]);

	assign offset[0] = hard_iron_q[AXIS_W-1:0];
	assign offset[1] = hard_iron_q[2*AXIS_W-1:AXIS_W];
	assign offset[2] = hard_iron_q[3*AXIS_W-1:2*AXIS_W];

	// halve the sum, rounding toward zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pair_sum[i] = (AXIS_W+1)'(prev_q[i]) + (AXIS_W+1)'(oriented[i]);
			pair_adj[i] = pair_sum[i] + {{AXIS_W{1'b0}}, pair_sum[i][AXIS_W]};
			avg_new[i]  = pair_adj[i][AXIS_W:1];
		end
	end

	// operand and tag for each sequencer step
	always_comb begin
		op_a = term_q[0];
		op_b = cxx_q;
		tag  = '0;
		case (step_q) inside
			[4'd0:4'd2]: begin
				op_a       = TERM_W'(scale_q);
				op_b       = prev_q[step_q[1:0]];
				tag.to_q12 = 1'b1;
				tag.idx    = step_q[1:0];
			end
			4'd3:  begin op_a = term_q[0]; op_b = cxx_q; tag.first = 1'b1; tag.idx = 2'd0; end
			4'd4:  begin op_a = term_q[1]; op_b = cxy_q; tag.idx = 2'd0; end
			4'd5:  begin op_a = term_q[2]; op_b = cxz_q; tag.last = 1'b1; tag.idx = 2'd0; end
			4'd6:  begin op_a = term_q[0]; op_b = cxy_q; tag.first = 1'b1; tag.idx = 2'd1; end
			4'd7:  begin op_a = term_q[1]; op_b = cyy_q; tag.idx = 2'd1; end
			4'd8:  begin op_a = term_q[2]; op_b = cyz_q; tag.last = 1'b1; tag.idx = 2'd1; end
			4'd9:  begin op_a = term_q[0]; op_b = cxz_q; tag.first = 1'b1; tag.idx = 2'd2; end
			4'd10: begin op_a = term_q[1]; op_b = cyz_q; tag.idx = 2'd2; end
			4'd11: begin op_a = term_q[2]; op_b = czz_q; tag.last = 1'b1; tag.idx = 2'd2; end
			default: begin
				tag = '0;
			end
		endcase
		tag.valid = (state_q == ST_RUN) && (step_q < STEP_W'(NUM_PROD));
	end

	mscu_mul_unit u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_a    (op_a),
		.op_b    (op_b),
		.tag     (tag),
		.prod_s1 (prod_s1),
		.tag_s1  (tag_s1)
	);

	mscu_acc_unit u_acc (
		.clk     (clk),
		.prod_s1 (prod_s1),
		.tag_s1  (tag_s1),
		.offset  (offset),
		.term_q  (term_q),
		.field_q (field_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			hard_iron_q <= HARD_IRON_RST;
			cxx_q       <= COEFF_XX_RST;
			cxy_q       <= COEFF_XY_RST;
			cxz_q       <= COEFF_XZ_RST;
			cyy_q       <= COEFF_YY_RST;
			cyz_q       <= COEFF_YZ_RST;
			czz_q       <= COEFF_ZZ_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_HARD_IRON: hard_iron_q <= cfg_data;
				REG_COEFF_XX:  cxx_q       <= cfg_data[AXIS_W-1:0];
				REG_COEFF_XY:  cxy_q       <= cfg_data[AXIS_W-1:0];
				REG_COEFF_XZ:  cxz_q       <= cfg_data[AXIS_W-1:0];
				REG_COEFF_YY:  cyy_q       <= cfg_data[AXIS_W-1:0];
				REG_COEFF_YZ:  cyz_q       <= cfg_data[AXIS_W-1:0];
				REG_COEFF_ZZ:  czz_q       <= cfg_data[AXIS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			// the finish step reloads the output itself
			if (out_valid_q && result.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						err_q  <= sample.payload.bus_error;
						step_q <= '0;
						if (sample.payload.bus_error) begin
							state_q <= ST_FINISH;
						end else begin
							for (int i = 0; i < 3; i++) begin
								prev_q[i] <= avg_new[i];
							end
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					// the final step only drains the last product
					if (step_q == STEP_W'(NUM_PROD)) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (err_q) begin
							out_q <= '{status: 1'b1, default: '0};
						end else begin
							out_q <= '{status: 1'b0,
								avg_x: prev_q[0], avg_y: prev_q[1], avg_z: prev_q[2],
								field_x: field_q[0], field_y: field_q[1],
								field_z: field_q[2]};
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(NUM_PROD))
		else $error("sequencer step out of range");

	a_err_keeps_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample.payload.bus_error) |=>
			($stable(prev_q[0]) && $stable(prev_q[1]) && $stable(prev_q[2])))
		else $error("failed read changed the kept averages");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == STEP_W'(NUM_PROD)) |=> (state_q == ST_FINISH))
		else $error("sequencer did not finish after the last product");

	a_mul_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> ($past(state_q) == ST_RUN))
		else $error("product issued outside the run state");

	a_err_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.status) |->
			(result.payload.field_x == '0 && result.payload.avg_x == '0))
		else $error("failed read result carries data");

endmodule

// ===== bench/magnetometer_sample_calibrator_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_sample_calibrator_unit_checker
// Watches the sample, result and register write ports of the calibrator. It
// keeps its own copy of the settings and of the running averages, works out
// the calibrated result of every accepted sample and compares each result
// transaction, field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module magnetometer_sample_calibrator_unit_checker
	import mscu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  sample_t               sample_payload,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_t               result_payload,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam longint FIELD_MAX = 64'sd2147483647;
	localparam longint FIELD_MIN = -64'sd2147483648;

	logic [SCALE_W-1:0]    scale;
	logic [CFG_DATA_W-1:0] offsets;
	s16_t                  c_xx, c_xy, c_xz, c_yy, c_yz, c_zz;
	s16_t                  kept_x, kept_y, kept_z;
	result_t               owed_results[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic s16_t mean_toward_zero(input s16_t kept, input s16_t fresh);
		int sum;
		sum = int'(kept) + int'(fresh);
		return s16_t'(sum / 2);
	endfunction

	// averaged count to Q.12 gauss, hard-iron offset removed
	function automatic longint offset_term(input s16_t avg, input s16_t offset);
		longint prod;
		prod = longint'(avg) * longint'(scale);
		return (prod >>> Q12_SHIFT) - longint'(offset);
	endfunction

	function automatic field_t soft_iron_row(input s16_t a, input s16_t b, input s16_t c,
		input longint tx, input longint ty, input longint tz);
		longint acc;
		acc = longint'(a) * tx + longint'(b) * ty + longint'(c) * tz;
		acc = acc >>> Q14_SHIFT;
		if (acc > FIELD_MAX) begin
			return field_t'(FIELD_MAX);
		end
		if (acc < FIELD_MIN) begin
			return field_t'(FIELD_MIN);
		end
		return field_t'(acc);
	endfunction

	// updates the kept averages unless the read failed
	function automatic result_t calibrate_sample(input sample_t s);
		result_t r;
		s16_t    raw_x, raw_y, raw_z;
		longint  t_x, t_y, t_z;
		r = '0;
		if (s.bus_error) begin
			r.status = 1'b1;
			return r;
		end
		raw_x = {s.byte_x_high, s.byte_x_low};
		raw_y = {s.byte_y_high, s.byte_y_low};
		raw_z = {s.byte_z_high, s.byte_z_low};
		raw_y = -raw_y;
		raw_z = -raw_z;
		kept_x = mean_toward_zero(kept_x, raw_x);
		kept_y = mean_toward_zero(kept_y, raw_y);
		kept_z = mean_toward_zero(kept_z, raw_z);
		t_x = offset_term(kept_x, offsets[15:0]);
		t_y = offset_term(kept_y, offsets[31:16]);
		t_z = offset_term(kept_z, offsets[47:32]);
		r.avg_x   = kept_x;
		r.avg_y   = kept_y;
		r.avg_z   = kept_z;
		r.field_x = soft_iron_row(c_xx, c_xy, c_xz, t_x, t_y, t_z);
		r.field_y = soft_iron_row(c_xy, c_yy, c_yz, t_x, t_y, t_z);
		r.field_z = soft_iron_row(c_xz, c_yz, c_zz, t_x, t_y, t_z);
		return r;
	endfunction

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			scale   = SCALE_RST;
			offsets = HARD_IRON_RST;
			c_xx    = COEFF_XX_RST;
			c_xy    = COEFF_XY_RST;
			c_xz    = COEFF_XZ_RST;
			c_yy    = COEFF_YY_RST;
			c_yz    = COEFF_YZ_RST;
			c_zz    = COEFF_ZZ_RST;
			kept_x  = '0;
			kept_y  = '0;
			kept_z  = '0;
			owed_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE:     scale   = cfg_data[SCALE_W-1:0];
					REG_HARD_IRON: offsets = cfg_data;
					REG_COEFF_XX:  c_xx    = cfg_data[15:0];
					REG_COEFF_XY:  c_xy    = cfg_data[15:0];
					REG_COEFF_XZ:  c_xz    = cfg_data[15:0];
					REG_COEFF_YY:  c_yy    = cfg_data[15:0];
					REG_COEFF_YZ:  c_yz    = cfg_data[15:0];
					REG_COEFF_ZZ:  c_zz    = cfg_data[15:0];
					default: ;
				endcase
			end
			// a result in this transaction always belongs to an earlier sample
			if (result_valid && result_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result transaction with no sample waiting");
				end else begin
					want = owed_results.pop_front();
					check_field("status", result_payload.status, want.status);
					check_field("avg_x", result_payload.avg_x, want.avg_x);
					check_field("avg_y", result_payload.avg_y, want.avg_y);
					check_field("avg_z", result_payload.avg_z, want.avg_z);
					check_field("field_x", result_payload.field_x, want.field_x);
					check_field("field_y", result_payload.field_y, want.field_y);
					check_field("field_z", result_payload.field_z, want.field_z);
				end
			end
			if (sample_valid && sample_ready) begin
				owed_results.push_back(calibrate_sample(sample_payload));
			end
		end
		outstanding = owed_results.size();
	end

endmodule

// ===== bench/magnetometer_sample_calibrator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_sample_calibrator_unit_test
// Drives raw samples and register writes into the calibrator: a directed
// pass over the extreme counts, the failed read and the wrapping negation
// under the reset, largest and zero settings, then random samples under a
// series of random settings, with bursts of idle and stall on both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module magnetometer_sample_calibrator_unit_test;
	import mscu_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int DRAIN_CYCLES     = 40;
	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 255;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	int                    cycle_count = 0;
	bit                    gaps_on;
	bit                    stalls_on;

	mscu_stream_if #(.payload_t(sample_t)) sample_ch ();
	mscu_stream_if #(.payload_t(result_t)) result_ch ();

	magnetometer_sample_calibrator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch.sink),
		.result    (result_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	magnetometer_sample_calibrator_unit_checker calib_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_ch.valid),
		.sample_ready   (sample_ch.ready),
		.sample_payload (sample_ch.payload),
		.result_valid   (result_ch.valid),
		.result_ready   (result_ch.ready),
		.result_payload (result_ch.payload),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("magnetometer_sample_calibrator_unit test failed");
			$finish;
		end
	end

	// result side: random stall bursts while enabled
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic sample_t make_sample(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z, input logic err);
		sample_t s;
		s.byte_x_low  = x[7:0];
		s.byte_x_high = x[15:8];
		s.byte_y_low  = y[7:0];
		s.byte_y_high = y[15:8];
		s.byte_z_low  = z[7:0];
		s.byte_z_high = z[15:8];
		s.bus_error   = err;
		return s;
	endfunction

	// word with extra weight on the edges of the signed range
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample();
		return make_sample(pick_word(), pick_word(), pick_word(), $urandom_range(0, 7) == 0);
	endfunction

	// random upper bits check that the block drops what lies above a register
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
		input int width);
		logic [63:0] junk;
		logic [CFG_DATA_W-1:0] mask;
		junk = {$urandom, $urandom};
		mask = (48'd1 << width) - 48'd1;
		return (junk[CFG_DATA_W-1:0] & ~mask) | (v & mask);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic write_all(input logic [SCALE_W-1:0] scale, input logic [47:0] offsets,
		input logic [15:0] xx, input logic [15:0] xy, input logic [15:0] xz,
		input logic [15:0] yy, input logic [15:0] yz, input logic [15:0] zz);
		write_reg(REG_SCALE, with_junk(48'(scale), SCALE_W));
		write_reg(REG_HARD_IRON, offsets);
		write_reg(REG_COEFF_XX, with_junk(48'(xx), AXIS_W));
		write_reg(REG_COEFF_XY, with_junk(48'(xy), AXIS_W));
		write_reg(REG_COEFF_XZ, with_junk(48'(xz), AXIS_W));
		write_reg(REG_COEFF_YY, with_junk(48'(yy), AXIS_W));
		write_reg(REG_COEFF_YZ, with_junk(48'(yz), AXIS_W));
		write_reg(REG_COEFF_ZZ, with_junk(48'(zz), AXIS_W));
	endtask

	task automatic random_settings();
		logic [SCALE_W-1:0] scale;
		case ($urandom_range(0, 3))
			0: scale = 24'hFFFFFF;
			1: scale = 24'($urandom_range(0, 255));
			2: scale = SCALE_RST + 24'($urandom_range(0, 4095));
			default: scale = 24'($urandom);
		endcase
		write_all(scale, {pick_word(), pick_word(), pick_word()}, pick_word(), pick_word(),
			pick_word(), pick_word(), pick_word(), pick_word());
	endtask

	task automatic send_sample(input sample_t s);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
		end
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.payload <= s;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// wait until every owed result is back and the block sits idle
	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.payload = '0;
		gaps_on           = 1'b1;
		stalls_on         = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: extremes, wrapping negation, odd negative sums, failed reads
		send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_sample(make_sample(16'h0001, 16'h0001, 16'h0001, 1'b0));
		send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_sample(make_sample(16'h1234, 16'hEDCB, 16'h8001, 1'b0));
		settle();

		// largest scale, most negative offsets and coefficients
		write_all(24'hFFFFFF, 48'h8000_8000_8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000);
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
		send_sample(make_sample(16'hFFFF, 16'h0000, 16'h8000, 1'b1));
		send_sample(make_sample(16'h8000, 16'h7FFF, 16'h8000, 1'b0));
		settle();

		// zero scale, largest offsets and coefficients
		write_all(24'h000000, 48'h7FFF_7FFF_7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_settings();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == RANDOM_PHASES - 1) begin
					gaps_on   = 1'b0;
					stalls_on = 1'b0;
				end else if (n % 40 == 0) begin
					gaps_on   = $urandom_range(0, 3) != 0;
					stalls_on = $urandom_range(0, 3) != 0;
				end
				send_sample(random_sample());
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("magnetometer_sample_calibrator_unit test passed");
		end else begin
			$display("magnetometer_sample_calibrator_unit test failed");
		end
		$finish;
	end

endmodule
